// ===== hdl/qxmm_pkg.sv =====
// ----------------------------------------------------------------------------
// qxmm_pkg
// Types and constants shared by the X-quad motor mixer and pulse-width fit.
// ----------------------------------------------------------------------------
package qxmm_pkg;

	localparam int unsigned NUM_MOTORS = 4;
	localparam int unsigned PULSE_W    = 12;

	localparam logic [PULSE_W-1:0] PULSE_MAX = 12'd4095;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_THRUST_GAIN     = 3'd0,
		REG_ROLL_PITCH_GAIN = 3'd1,
		REG_YAW_GAIN        = 3'd2,
		REG_POLY_SQUARE     = 3'd3,
		REG_POLY_LINEAR     = 3'd4,
		REG_POLY_OFFSET     = 3'd5
	} cfg_reg_t;

	// reset values
	localparam logic [31:0] THRUST_GAIN_RST     = 32'd1241212;
	localparam logic [31:0] ROLL_PITCH_GAIN_RST = 32'd7632;
	localparam logic [31:0] YAW_GAIN_RST        = 32'd75502;
	localparam logic [31:0] POLY_SQUARE_MAG_RST = 32'd385621;
	localparam logic        POLY_SQUARE_NEG_RST = 1'b1;
	localparam logic [31:0] POLY_LINEAR_RST     = 32'd9706626;
	localparam logic [31:0] POLY_OFFSET_RST     = 32'd70556058;

	// mixing signs, bit i set where motor i takes the negative term
	localparam logic [NUM_MOTORS-1:0] NEG_ROLL  = 4'b1100;
	localparam logic [NUM_MOTORS-1:0] NEG_PITCH = 4'b1001;
	localparam logic [NUM_MOTORS-1:0] NEG_YAW   = 4'b1010;

	// live configuration, quadratic coefficient kept as sign and magnitude
	typedef struct packed {
		logic        [31:0] thrust_gain;
		logic        [31:0] roll_pitch_gain;
		logic        [31:0] yaw_gain;
		logic        [31:0] a2_mag;
		logic               a2_neg;
		logic signed [31:0] a1;
		logic        [31:0] a0;
	} cfg_t;

	// one motor lane result
	typedef struct packed {
		logic               vld;
		logic [PULSE_W-1:0] pulse;
		logic               clamp;
	} lane_res_t;

endpackage

// ===== hdl/qxmm_cfg.sv =====
// ----------------------------------------------------------------------------
// qxmm_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module qxmm_cfg
	import qxmm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output cfg_t        cfg
);

	logic        [31:0] thrust_gain_q;
	logic        [31:0] roll_pitch_gain_q;
	logic        [31:0] yaw_gain_q;
	logic        [31:0] a2_mag_q;
	logic               a2_neg_q;
	logic signed [31:0] a1_q;
	logic        [31:0] a0_q;

	// magnitude of a negative word, -2^31 maps to 2^31
	logic [31:0] data_neg;
	assign data_neg = (~cfg_data) + 32'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thrust_gain_q     <= THRUST_GAIN_RST;
			roll_pitch_gain_q <= ROLL_PITCH_GAIN_RST;
			yaw_gain_q        <= YAW_GAIN_RST;
			a2_mag_q          <= POLY_SQUARE_MAG_RST;
			a2_neg_q          <= POLY_SQUARE_NEG_RST;
			a1_q              <= POLY_LINEAR_RST;
			a0_q              <= POLY_OFFSET_RST;
		end else if (cfg_wr_en) begin
			case (cfg_reg_t'(cfg_index))
				REG_THRUST_GAIN:     thrust_gain_q     <= cfg_data;
				REG_ROLL_PITCH_GAIN: roll_pitch_gain_q <= cfg_data;
				REG_YAW_GAIN:        yaw_gain_q        <= cfg_data;
				REG_POLY_SQUARE: begin
					a2_neg_q <= cfg_data[31];
					a2_mag_q <= cfg_data[31] ? data_neg : cfg_data;
				end
				REG_POLY_LINEAR:     a1_q              <= cfg_data;
				REG_POLY_OFFSET:     a0_q              <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg.thrust_gain     = thrust_gain_q;
	assign cfg.roll_pitch_gain = roll_pitch_gain_q;
	assign cfg.yaw_gain        = yaw_gain_q;
	assign cfg.a2_mag          = a2_mag_q;
	assign cfg.a2_neg          = a2_neg_q;
	assign cfg.a1              = a1_q;
	assign cfg.a0              = a0_q;

endmodule

// ===== hdl/qxmm_mix.sv =====
// ----------------------------------------------------------------------------
// qxmm_mix
// Mixing front end: gain products, per-motor signed sums, rounding to an
// integer squared speed with 32-bit saturation. Three stages.
// ----------------------------------------------------------------------------
module qxmm_mix
	import qxmm_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_vld,
	input  logic [15:0]               thrust_mn,
	input  logic signed [23:0]        torque_roll,
	input  logic signed [23:0]        torque_pitch,
	input  logic signed [23:0]        torque_yaw,
	input  cfg_t                      cfg,
	output logic                      out_vld,
	output logic signed [31:0]        w_out [NUM_MOTORS]
);

	localparam logic signed [41:0] W_HI = 42'sd2147483647;
	localparam logic signed [41:0] W_LO = -42'sd2147483648;

	// stage 1: gain products
	logic               vld_s1;
	logic        [47:0] base_s1;
	logic signed [56:0] rx_s1;
	logic signed [56:0] ry_s1;
	logic signed [56:0] rz_s1;

	// stage 2: per-motor Q16 squared speed
	logic               vld_s2;
	logic signed [57:0] wq_s2 [NUM_MOTORS];

	// stage 3: rounded, saturated squared speed
	logic               vld_s3;
	logic signed [31:0] w_s3 [NUM_MOTORS];

	logic signed [57:0] wq_c [NUM_MOTORS];
	logic signed [31:0] w_c  [NUM_MOTORS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (in_vld) begin
			base_s1 <= 48'(cfg.thrust_gain) * 48'(thrust_mn);
			rx_s1   <= 57'($signed({1'b0, cfg.roll_pitch_gain})) * 57'(torque_roll);
			ry_s1   <= 57'($signed({1'b0, cfg.roll_pitch_gain})) * 57'(torque_pitch);
			rz_s1   <= 57'($signed({1'b0, cfg.yaw_gain})) * 57'(torque_yaw);
		end
	end

	always_comb begin
		for (int i = 0; i < NUM_MOTORS; i++) begin
			logic signed [57:0] tx;
			logic signed [57:0] ty;
			logic signed [57:0] tz;
			tx = NEG_ROLL[i]  ? -58'(rx_s1) : 58'(rx_s1);
			ty = NEG_PITCH[i] ? -58'(ry_s1) : 58'(ry_s1);
			tz = NEG_YAW[i]   ? -58'(rz_s1) : 58'(rz_s1);
			wq_c[i] = $signed({10'd0, base_s1}) + tx + ty + tz;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			wq_s2 <= wq_c;
		end
	end

	// round half up, then saturate
	always_comb begin
		for (int i = 0; i < NUM_MOTORS; i++) begin
			logic signed [57:0] r;
			logic signed [41:0] q;
			r = wq_s2[i] + 58'sd32768;
			q = r[57:16];
			if (q > W_HI) begin
				w_c[i] = W_HI[31:0];
			end else if (q < W_LO) begin
				w_c[i] = W_LO[31:0];
			end else begin
				w_c[i] = q[31:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s2) begin
			w_s3 <= w_c;
		end
	end

	assign out_vld = vld_s3;
	assign w_out   = w_s3;

endmodule

// ===== hdl/qxmm_poly.sv =====
// ----------------------------------------------------------------------------
// qxmm_poly
// One motor lane of the pulse-width fit a2*W^2 + a1*W + a0, rounded and
// clamped to the pulse range. Five stages.
// ----------------------------------------------------------------------------
module qxmm_poly
	import qxmm_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_vld,
	input  logic signed [31:0] w_in,
	input  cfg_t               cfg,
	output lane_res_t          res
);

	// stage 4: square and linear products
	logic               vld_s4;
	logic        [62:0] sq_s4;
	logic signed [63:0] lin_s4;

	// stage 5: split square-term products, truncated linear term
	logic               vld_s5;
	logic        [62:0] phi_s5;
	logic        [63:0] plo_s5;
	logic signed [47:0] t1_s5;

	// stage 6: square-term magnitude
	logic               vld_s6;
	logic        [61:0] t2m_s6;
	logic signed [47:0] t1_s6;

	// stage 7: rounded pulse
	logic               vld_s7;
	logic signed [47:0] p_s7;

	// stage 8: clamped pulse
	logic               vld_s8;
	logic [PULSE_W-1:0] pulse_s8;
	logic               clamp_s8;

	logic signed [63:0] sq_full;
	logic signed [63:0] lin_full;
	logic signed [63:0] lin_adj;
	logic signed [63:0] t2s;
	logic signed [63:0] sum_c;

	assign sq_full  = 64'(w_in) * 64'(w_in);
	assign lin_full = 64'($signed(cfg.a1)) * 64'(w_in);

	// truncation toward zero
	assign lin_adj = lin_s4 + (lin_s4[63] ? 64'sd65535 : 64'sd0);

	assign t2s   = cfg.a2_neg ? -$signed({2'b00, t2m_s6}) : $signed({2'b00, t2m_s6});
	assign sum_c = t2s + 64'(t1_s6) + $signed({32'd0, cfg.a0}) + 64'sd32768;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else begin
			vld_s4 <= in_vld;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (in_vld) begin
			sq_s4  <= sq_full[62:0];
			lin_s4 <= lin_full;
		end
		if (vld_s4) begin
			phi_s5 <= 63'(cfg.a2_mag) * 63'(sq_s4[62:32]);
			plo_s5 <= 64'(cfg.a2_mag) * 64'(sq_s4[31:0]);
			t1_s5  <= lin_adj[63:16];
		end
		if (vld_s5) begin
			t2m_s6 <= 62'(phi_s5) + 62'(plo_s5[63:32]);
			t1_s6  <= t1_s5;
		end
		if (vld_s6) begin
			p_s7 <= sum_c[63:16];
		end
		if (vld_s7) begin
			if (p_s7 < 48'sd0) begin
				pulse_s8 <= '0;
				clamp_s8 <= 1'b1;
			end else if (p_s7 > $signed({36'd0, PULSE_MAX})) begin
				pulse_s8 <= PULSE_MAX;
				clamp_s8 <= 1'b1;
			end else begin
				pulse_s8 <= p_s7[PULSE_W-1:0];
				clamp_s8 <= 1'b0;
			end
		end
	end

	assign res.vld   = vld_s8;
	assign res.pulse = pulse_s8;
	assign res.clamp = clamp_s8;

`ifndef SYNTHESIS
	// a clamped pulse sits on a range end
	assert property (@(posedge clk) disable iff (!arst_n)
		vld_s8 && clamp_s8 |-> (pulse_s8 == PULSE_MAX) || (pulse_s8 == '0))
		else $error("clamped pulse not at a range end");

	// valid walks the five lane stages
	assert property (@(posedge clk) disable iff (!arst_n)
		in_vld |-> ##5 vld_s8)
		else $error("lane valid lost");

	// the square-term magnitude never exceeds 2^61
	assert property (@(posedge clk) disable iff (!arst_n)
		vld_s6 |-> !t2m_s6[61] || (t2m_s6[60:0] == '0))
		else $error("square term out of range");
`endif

endmodule

// ===== hdl/quad_x_motor_mixer_pwm.sv =====
// ----------------------------------------------------------------------------
// quad_x_motor_mixer_pwm
// X-quad motor mixer followed by a quadratic pulse-width fit per motor.
//
//   channel   direction  handshake               payload
//   command   in         start, busy             thrust_mn, torque_roll,
//                                                torque_pitch, torque_yaw
//   result    out        done (one-cycle strobe) pulse_w, pulse_x, pulse_y,
//                                                pulse_z, clamped
//   config    in         cfg_wr_en               cfg_index, cfg_data
//
// a transaction is taken when start is high and busy is low; busy is high
// only while in reset and on the first edge after release, then stays low
// one command per cycle once busy is low; done follows accept through the
// multiplier chain registers: gain products, sums, rounding, square and
// linear products, split square-term products, square-term magnitude,
// final add, clamp; the receiver cannot stall, so the pipeline never
// holds; done is a registered strobe lasting one cycle per transaction
// reset clears the valid bits and loads the register defaults
// ----------------------------------------------------------------------------
module quad_x_motor_mixer_pwm
	import qxmm_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	// command
	input  logic               start,
	output logic               busy,
	input  logic [15:0]        thrust_mn,
	input  logic signed [23:0] torque_roll,
	input  logic signed [23:0] torque_pitch,
	input  logic signed [23:0] torque_yaw,
	// result
	output logic               done,
	output logic [11:0]        pulse_w,
	output logic [11:0]        pulse_x,
	output logic [11:0]        pulse_y,
	output logic [11:0]        pulse_z,
	output logic               clamped,
	// configuration
	input  logic               cfg_wr_en,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data
);

	cfg_t               cfg;
	logic               busy_q;
	logic               accept;
	logic               mix_vld;
	logic signed [31:0] w_lane [NUM_MOTORS];
	lane_res_t          lane   [NUM_MOTORS];
	logic [NUM_MOTORS-1:0] lane_vld;

	// hold off the first edge after reset release
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
		end else begin
			busy_q <= 1'b0;
		end
	end

	assign busy   = busy_q;
	assign accept = start && !busy_q;

	qxmm_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// squared speed per motor
	qxmm_mix u_mix (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_vld       (accept),
		.thrust_mn    (thrust_mn),
		.torque_roll  (torque_roll),
		.torque_pitch (torque_pitch),
		.torque_yaw   (torque_yaw),
		.cfg          (cfg),
		.out_vld      (mix_vld),
		.w_out        (w_lane)
	);

	// one pulse-width lane per motor
	for (genvar i = 0; i < NUM_MOTORS; i++) begin : g_lane
		qxmm_poly u_poly (
			.clk    (clk),
			.arst_n (arst_n),
			.in_vld (mix_vld),
			.w_in   (w_lane[i]),
			.cfg    (cfg),
			.res    (lane[i])
		);
		assign lane_vld[i] = lane[i].vld;
	end

	// output order: w = motor 3, x = motor 1, y = motor 0, z = motor 2
	assign done    = lane_vld[0];
	assign pulse_w = lane[3].pulse;
	assign pulse_x = lane[1].pulse;
	assign pulse_y = lane[0].pulse;
	assign pulse_z = lane[2].pulse;
	assign clamped = lane[0].clamp || lane[1].clamp || lane[2].clamp || lane[3].clamp;

`ifndef SYNTHESIS
	// every accepted command gives a result through the mixer and lane stages
	assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##8 done)
		else $error("result missing for accepted command");

	// no result without an earlier accepted command
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, 8))
		else $error("result without a command");

	// the four lanes stay in step
	assert property (@(posedge clk) disable iff (!arst_n)
		(lane_vld == '0) || (lane_vld == '1))
		else $error("motor lanes out of step");
`endif

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the X-quad motor mixer with quadratic pulse fit.
// A directed table covers zero and full-scale thrust and torques, clamping
// at both ends, unmapped register writes and extreme coefficients. Random
// commands follow over a series of register settings, from the defaults to
// the extremes. Results are checked against an in-bench fixed-point model
// of the mixer and the fit, or against a typed value on some directed rows.
// ----------------------------------------------------------------------------
module testbench;
	import qxmm_pkg::*;

	localparam int CLK_HALF     = 4;
	localparam int RESET_CYCLES = 10;
	localparam int PIPE_LATENCY = 8;
	localparam int STALL_LIMIT  = 2000;
	localparam int MAX_REPORTS  = 10;
	localparam int NUM_REGS     = 6;
	localparam int RAND_PHASES  = 12;
	localparam int PHASE_CMDS   = 140;

	// indexes that map to no register
	localparam logic [2:0] REG_UNMAPPED_A = 3'd6;
	localparam logic [2:0] REG_UNMAPPED_B = 3'd7;

	// mixing signs, bit m set where motor m takes the negated torque term
	localparam logic [3:0] ROLL_NEG  = 4'b1100;
	localparam logic [3:0] PITCH_NEG = 4'b1001;
	localparam logic [3:0] YAW_NEG   = 4'b1010;

	// squared speed saturates to the signed 32-bit range
	localparam longint W_HI      = 64'sd2147483647;
	localparam longint W_LO      = -W_HI - 1;
	localparam longint HALF_LSB  = 64'sd32768;
	localparam longint PULSE_TOP = 64'sd4095;

	localparam logic [15:0]        THRUST_MAX = 16'hFFFF;
	localparam logic signed [23:0] TORQUE_MAX = 24'sh7FFFFF;
	localparam logic signed [23:0] TORQUE_MIN = 24'sh800000;

	// zero demand at default coefficients: offset 70556058 / 2^16 rounds to 1077
	localparam logic [11:0] IDLE_PULSE = 12'd1077;

	typedef enum bit {ROW_CMD, ROW_REG} row_kind_t;

	typedef struct packed {
		logic [15:0]        thrust;
		logic signed [23:0] roll;
		logic signed [23:0] pitch;
		logic signed [23:0] yaw;
	} mix_cmd_t;

	typedef struct packed {
		logic [11:0] w;
		logic [11:0] x;
		logic [11:0] y;
		logic [11:0] z;
		logic        clamp;
	} pulse_set_t;

	// live register copy for the model, a2 and a1 kept signed
	typedef struct {
		bit [31:0] thrust_gain;
		bit [31:0] rp_gain;
		bit [31:0] yaw_gain;
		int        a2;
		int        a1;
		bit [31:0] a0;
	} mix_cfg_t;

	typedef struct {
		row_kind_t  kind;
		logic [2:0] idx;
		logic [31:0] data;
		mix_cmd_t   cmd;
		bit         typed;
		pulse_set_t want;
	} stim_row_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [15:0]        thrust_mn;
	logic signed [23:0] torque_roll;
	logic signed [23:0] torque_pitch;
	logic signed [23:0] torque_yaw;
	logic               done;
	logic [11:0]        pulse_w;
	logic [11:0]        pulse_x;
	logic [11:0]        pulse_y;
	logic [11:0]        pulse_z;
	logic               clamped;
	logic               cfg_wr_en;
	logic [2:0]         cfg_index;
	logic [31:0]        cfg_data;

	mix_cfg_t   mixer_cfg;
	pulse_set_t pending_pulses[$];
	stim_row_t  directed_rows[$];

	// typed expectation waiting for the next directed command row
	bit         next_typed = 1'b0;
	pulse_set_t next_want  = '0;

	int cmds_sent    = 0;
	int results_seen = 0;
	int reg_writes   = 0;
	int fail_count   = 0;
	int idle_cycles  = 0;

	quad_x_motor_mixer_pwm i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.thrust_mn    (thrust_mn),
		.torque_roll  (torque_roll),
		.torque_pitch (torque_pitch),
		.torque_yaw   (torque_yaw),
		.done         (done),
		.pulse_w      (pulse_w),
		.pulse_x      (pulse_x),
		.pulse_y      (pulse_y),
		.pulse_z      (pulse_z),
		.clamped      (clamped),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// register model
	// ------------------------------------------------------------------------

	function automatic logic [31:0] reg_default(input logic [2:0] idx);
		case (idx)
			REG_THRUST_GAIN:     return 32'd1241212;
			REG_ROLL_PITCH_GAIN: return 32'd7632;
			REG_YAW_GAIN:        return 32'd75502;
			REG_POLY_SQUARE:     return -32'sd385621;
			REG_POLY_LINEAR:     return 32'd9706626;
			REG_POLY_OFFSET:     return 32'd70556058;
			default:             return '0;
		endcase
	endfunction

	// unmapped indexes leave every register alone
	function automatic void apply_reg(input logic [2:0] idx, input logic [31:0] v);
		case (idx)
			REG_THRUST_GAIN:     mixer_cfg.thrust_gain = v;
			REG_ROLL_PITCH_GAIN: mixer_cfg.rp_gain = v;
			REG_YAW_GAIN:        mixer_cfg.yaw_gain = v;
			REG_POLY_SQUARE:     mixer_cfg.a2 = int'(v);
			REG_POLY_LINEAR:     mixer_cfg.a1 = int'(v);
			REG_POLY_OFFSET:     mixer_cfg.a0 = v;
			default: ;
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// mixer and pulse-fit model
	// ------------------------------------------------------------------------

	// Q16 squared speed in, pulse width out, clip set when clamped
	function automatic logic [11:0] fit_pulse(input longint wq16, output bit clip);
		longint      w, t1, t2, lin, sum, p;
		logic [127:0] sq, mag, prod;
		clip = 1'b0;
		// round half up to whole squared speed, then saturate
		w = (wq16 + HALF_LSB) >>> 16;
		if (w > W_HI) w = W_HI;
		if (w < W_LO) w = W_LO;
		// square term: |a2| * W^2 scaled Q48 -> Q16, truncated toward zero
		sq   = 128'((w < 0) ? -w : w);
		sq   = sq * sq;
		mag  = 128'((mixer_cfg.a2 < 0) ? -longint'(mixer_cfg.a2) : longint'(mixer_cfg.a2));
		prod = mag * sq;
		t2   = longint'(prod >> 32);
		if (mixer_cfg.a2 < 0) t2 = -t2;
		// linear term: a1 * W scaled Q32 -> Q16, truncated toward zero
		lin = longint'(mixer_cfg.a1) * w;
		t1  = (lin < 0) ? -((-lin) >>> 16) : (lin >>> 16);
		sum = t2 + t1 + longint'(mixer_cfg.a0);
		p   = (sum + HALF_LSB) >>> 16;
		if (p < 0) begin
			clip = 1'b1;
			return '0;
		end
		if (p > PULSE_TOP) begin
			clip = 1'b1;
			return 12'(PULSE_TOP);
		end
		return 12'(p);
	endfunction

	function automatic pulse_set_t predict_pulses(input mix_cmd_t c);
		longint      base, rx, ry, rz, wq;
		logic [11:0] pw [4];
		bit          clip, any_clip;
		pulse_set_t  r;
		any_clip = 1'b0;
		base = longint'(mixer_cfg.thrust_gain) * longint'(c.thrust);
		rx   = longint'(mixer_cfg.rp_gain) * longint'(signed'(c.roll));
		ry   = longint'(mixer_cfg.rp_gain) * longint'(signed'(c.pitch));
		rz   = longint'(mixer_cfg.yaw_gain) * longint'(signed'(c.yaw));
		for (int m = 0; m < 4; m++) begin
			wq = base + (ROLL_NEG[m] ? -rx : rx) + (PITCH_NEG[m] ? -ry : ry)
			     + (YAW_NEG[m] ? -rz : rz);
			pw[m] = fit_pulse(wq, clip);
			any_clip |= clip;
		end
		// port order: w = motor 3, x = motor 1, y = motor 0, z = motor 2
		r.w     = pw[3];
		r.x     = pw[1];
		r.y     = pw[0];
		r.z     = pw[2];
		r.clamp = any_clip;
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------------

	function automatic void type_next(input logic [11:0] pulse, input logic clamp);
		next_typed = 1'b1;
		next_want  = {pulse, pulse, pulse, pulse, clamp};
	endfunction

	function automatic void add_cmd_row(input logic [15:0] t,
	                                    input logic signed [23:0] r, p, y);
		stim_row_t row;
		row.kind       = ROW_CMD;
		row.idx        = '0;
		row.data       = '0;
		row.cmd.thrust = t;
		row.cmd.roll   = r;
		row.cmd.pitch  = p;
		row.cmd.yaw    = y;
		row.typed      = next_typed;
		row.want       = next_want;
		next_typed     = 1'b0;
		directed_rows.push_back(row);
	endfunction

	function automatic void add_reg_row(input logic [2:0] idx, input logic [31:0] v);
		stim_row_t row;
		row.kind  = ROW_REG;
		row.idx   = idx;
		row.data  = v;
		row.cmd   = '0;
		row.typed = 1'b0;
		row.want  = '0;
		directed_rows.push_back(row);
	endfunction

	// mostly near the defaults so the fit stays in range, plus extremes and noise
	function automatic logic [31:0] pick_reg_value(input logic [2:0] idx);
		int          dflt, span;
		logic [31:0] v;
		dflt = int'(reg_default(idx));
		span = (dflt < 0 ? -dflt : dflt) / 2;
		case ($urandom_range(0, 19))
			0, 1, 2, 3:   v = reg_default(idx);
			4, 5, 6:      v = $urandom;
			7, 8, 9, 10: begin
				case ($urandom_range(0, 3))
					0:       v = '0;
					1:       v = '1;
					2:       v = 32'h8000_0000;
					default: v = 32'h7FFF_FFFF;
				endcase
			end
			default:      v = 32'(dflt + int'($urandom_range(0, 2 * span)) - span);
		endcase
		return v;
	endfunction

	// random magnitude spread: full range, extremes, and sign-kept shifts down
	function automatic logic signed [23:0] rand_torque();
		logic signed [23:0] v;
		v = 24'($urandom);
		case ($urandom_range(0, 9))
			0:       v = TORQUE_MAX;
			1:       v = TORQUE_MIN;
			2, 3:    ;
			default: v = v >>> $urandom_range(4, 23);
		endcase
		return v;
	endfunction

	function automatic mix_cmd_t rand_cmd();
		mix_cmd_t c;
		case ($urandom_range(0, 9))
			0:       c.thrust = '0;
			1:       c.thrust = THRUST_MAX;
			default: c.thrust = 16'($urandom);
		endcase
		c.roll  = rand_torque();
		c.pitch = rand_torque();
		c.yaw   = rand_torque();
		return c;
	endfunction

	// ------------------------------------------------------------------------
	// drivers, all entered and left at a falling edge
	// ------------------------------------------------------------------------

	// random idle cycles first, then hold start until the transaction is taken
	task automatic send_cmd(input mix_cmd_t c, input pulse_set_t want, input int idle_pct);
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start        <= 1'b1;
		thrust_mn    <= c.thrust;
		torque_roll  <= c.roll;
		torque_pitch <= c.pitch;
		torque_yaw   <= c.yaw;
		@(posedge clk);
		while (busy !== 1'b0) @(posedge clk);
		pending_pulses.push_back(want);
		cmds_sent++;
		@(negedge clk);
	endtask

	// stop sending until every outstanding result has come back
	task automatic wait_drained();
		start <= 1'b0;
		do @(negedge clk); while (pending_pulses.size() != 0);
	endtask

	// raises the write enable only; the caller lowers it after the batch
	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		apply_reg(idx, val);
		reg_writes++;
		@(negedge clk);
	endtask

	function automatic void report_fail(input string what, input pulse_set_t want,
	                                    input pulse_set_t got);
		fail_count++;
		if (fail_count <= MAX_REPORTS)
			$display("%0t %s: expected w=%0d x=%0d y=%0d z=%0d clamp=%0b,",
			         $realtime, what, want.w, want.x, want.y, want.z, want.clamp,
			         " got w=%0d x=%0d y=%0d z=%0d clamp=%0b",
			         got.w, got.x, got.y, got.z, got.clamp);
	endfunction

	// ------------------------------------------------------------------------
	// result checker: every done strobe is a transaction, no back-pressure
	// ------------------------------------------------------------------------

	always @(posedge clk) begin : result_check
		pulse_set_t got, want;
		if (arst_n === 1'b1 && done === 1'b1) begin
			got.w     = pulse_w;
			got.x     = pulse_x;
			got.y     = pulse_y;
			got.z     = pulse_z;
			got.clamp = clamped;
			if (pending_pulses.size() == 0) begin
				report_fail("result with no command outstanding", '0, got);
			end else begin
				want = pending_pulses.pop_front();
				results_seen++;
				if (got.w !== want.w || got.x !== want.x || got.y !== want.y ||
				    got.z !== want.z || got.clamp !== want.clamp)
					report_fail("pulse mismatch", want, got);
			end
		end
	end

	// watchdog: cycles with neither a command taken nor a result delivered
	always @(posedge clk) begin
		if ((start === 1'b1 && busy === 1'b0) || done === 1'b1)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------------

	initial begin
		stim_row_t row;
		mix_cmd_t  c;
		bit        prev_cmd;
		int        idle_pct;
		int        n_directed;

		arst_n       = 1'b0;
		start        = 1'b0;
		thrust_mn    = '0;
		torque_roll  = '0;
		torque_pitch = '0;
		torque_yaw   = '0;
		cfg_wr_en    = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		for (int i = 0; i < NUM_REGS; i++) apply_reg(3'(i), reg_default(3'(i)));

		// directed table, default coefficients first
		type_next(IDLE_PULSE, 1'b0);
		add_cmd_row('0, '0, '0, '0);
		add_cmd_row(THRUST_MAX, '0, '0, '0);
		add_cmd_row('0, TORQUE_MAX, '0, '0);
		add_cmd_row('0, TORQUE_MIN, '0, '0);
		add_cmd_row('0, '0, TORQUE_MAX, '0);
		add_cmd_row('0, '0, TORQUE_MIN, '0);
		add_cmd_row('0, '0, '0, TORQUE_MAX);
		add_cmd_row('0, '0, '0, TORQUE_MIN);
		add_cmd_row(THRUST_MAX, TORQUE_MAX, TORQUE_MAX, TORQUE_MAX);
		add_cmd_row(THRUST_MAX, TORQUE_MIN, TORQUE_MIN, TORQUE_MIN);
		add_cmd_row(16'd3000, 24'sd20000, -24'sd15000, 24'sd40000);
		add_cmd_row(16'h5555, 24'shAAAAAA, 24'sh555555, 24'shAAAAAA);
		// fit reduced to a full-scale offset: every width clamps high
		add_reg_row(REG_POLY_SQUARE, '0);
		add_reg_row(REG_POLY_LINEAR, '0);
		add_reg_row(REG_POLY_OFFSET, '1);
		type_next(PULSE_MAX, 1'b1);
		add_cmd_row('0, '0, '0, '0);
		// fit reduced to zero: output zero whatever the demand
		add_reg_row(REG_POLY_OFFSET, '0);
		type_next('0, 1'b0);
		add_cmd_row('0, '0, '0, '0);
		// writes to unmapped indexes must not land anywhere
		add_reg_row(REG_UNMAPPED_A, '1);
		add_reg_row(REG_UNMAPPED_B, 32'h1234_5678);
		type_next('0, 1'b0);
		add_cmd_row(THRUST_MAX, TORQUE_MAX, TORQUE_MIN, TORQUE_MAX);
		// full-scale gains saturate the squared speed, extreme coefficients
		add_reg_row(REG_THRUST_GAIN, '1);
		add_reg_row(REG_ROLL_PITCH_GAIN, '1);
		add_reg_row(REG_YAW_GAIN, '1);
		add_reg_row(REG_POLY_SQUARE, 32'h8000_0000);
		add_reg_row(REG_POLY_LINEAR, 32'h7FFF_FFFF);
		add_cmd_row(THRUST_MAX, TORQUE_MAX, TORQUE_MAX, TORQUE_MAX);
		add_cmd_row('0, TORQUE_MIN, TORQUE_MIN, TORQUE_MIN);
		add_cmd_row(16'd1, '0, '0, '0);
		add_reg_row(REG_POLY_SQUARE, 32'h7FFF_FFFF);
		add_reg_row(REG_POLY_LINEAR, 32'h8000_0000);
		add_reg_row(REG_POLY_OFFSET, '1);
		add_cmd_row(THRUST_MAX, TORQUE_MAX, TORQUE_MAX, TORQUE_MAX);
		add_cmd_row('0, TORQUE_MIN, TORQUE_MIN, TORQUE_MIN);
		add_cmd_row(16'd1, '0, '0, '0);
		add_reg_row(REG_THRUST_GAIN, '0);
		add_reg_row(REG_ROLL_PITCH_GAIN, '0);
		add_reg_row(REG_YAW_GAIN, '0);
		add_cmd_row(THRUST_MAX, TORQUE_MAX, TORQUE_MIN, TORQUE_MAX);

		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;

		// walk the table, draining before each batch of register writes
		prev_cmd = 1'b0;
		foreach (directed_rows[n]) begin
			row = directed_rows[n];
			if (row.kind == ROW_REG) begin
				if (prev_cmd) wait_drained();
				write_reg(row.idx, row.data);
				prev_cmd = 1'b0;
			end else begin
				cfg_wr_en <= 1'b0;
				send_cmd(row.cmd, row.typed ? row.want : predict_pulses(row.cmd), 0);
				prev_cmd = 1'b1;
			end
		end
		n_directed = cmds_sent;

		// random phases: sender idles 8%, then 49%, then back to back
		// each phase starts with a full drain, so the sender waits out every
		// outstanding result before the registers move
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			wait_drained();
			for (int i = 0; i < NUM_REGS; i++)
				if (ph == 0)
					write_reg(3'(i), reg_default(3'(i)));
				else if ($urandom_range(0, 9) < 7)
					write_reg(3'(i), pick_reg_value(3'(i)));
			if ($urandom_range(0, 3) == 0)
				write_reg($urandom_range(0, 1) ? REG_UNMAPPED_A : REG_UNMAPPED_B, $urandom);
			cfg_wr_en <= 1'b0;
			idle_pct = (ph < RAND_PHASES / 3) ? 8 : (ph < 2 * RAND_PHASES / 3) ? 49 : 0;
			repeat (PHASE_CMDS) begin
				c = rand_cmd();
				send_cmd(c, predict_pulses(c), idle_pct);
			end
		end

		// let the pipeline empty, then watch a little longer for strays
		wait_drained();
		repeat (PIPE_LATENCY + 8) @(posedge clk);

		$display("covered %0d mixer commands (%0d from the directed table), %0d results checked",
		         cmds_sent, n_directed, results_seen);
		$display("register writes: %0d over %0d settings, failures: %0d",
		         reg_writes, RAND_PHASES + 1, fail_count);
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
